// File: src/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection pipeline.
// No dependencies; imported by every module of the block.
package rti_pkg;

    // Fixed field widths
    localparam int CW      = 20;            // coordinate width, Q8.12
    localparam int TW      = CW + 1;        // origin minus vertex
    localparam int PW      = 2 * CW + 1;    // one cross product term
    localparam int XW      = 2 * CW + 2;    // cross product component
    localparam int SPLIT_W = CW + 1;        // low slice of a cross component
    localparam int DW      = 3 * CW + 4;    // dot product / determinant
    localparam int QW      = 24;            // quotient bits per divider lane
    localparam int DIST_W  = 24;
    localparam int BARY_W  = 17;
    localparam int NRM_W   = 16;
    localparam int CFG_W   = 3 * CW;
    localparam int NLANE   = 3;

    // Divider lanes
    localparam int LANE_D = 0;
    localparam int LANE_B = 1;
    localparam int LANE_G = 2;

    // Dot products
    localparam int DOT_DET = 0;
    localparam int DOT_U   = 1;
    localparam int DOT_V   = 2;
    localparam int DOT_W   = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_VERTEX = 2'd0;
    localparam logic [1:0] CFG_EDGE1  = 2'd1;
    localparam logic [1:0] CFG_EDGE2  = 2'd2;
    localparam logic [1:0] CFG_NORMAL = 2'd3;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_vec3;

    typedef struct packed {
        logic                  action;
        t_coord                origin_x;
        t_coord                origin_y;
        t_coord                origin_z;
        t_coord                dir_x;
        t_coord                dir_y;
        t_coord                dir_z;
        logic [DIST_W-1:0]     distance_limit;
    } t_ray_in;

    typedef struct packed {
        logic                    hit;
        logic [DIST_W-1:0]       hit_distance;
        logic [BARY_W-1:0]       beta;
        logic [BARY_W-1:0]       gamma;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
    } t_hit_out;

    // Per-ray sideband carried down the pipe
    typedef struct packed {
        logic              action;
        logic [DIST_W-1:0] limit;
    } t_side;

    typedef struct packed {
        t_side                side;
        logic signed [DW-1:0] det;
        logic signed [DW-1:0] u;
        logic signed [DW-1:0] v;
        logic signed [DW-1:0] w;
    } t_dots;

    // Divider state: remainder and shift/quotient word per lane
    typedef struct packed {
        t_side                       side;
        logic                        ok;
        logic [DW-1:0]               det;
        logic [NLANE-1:0][DW-1:0]    rem;
        logic [NLANE-1:0][QW-1:0]    x;
    } t_divs;

endpackage

// File: src/rti_front.sv
// Vector front end: edge setup, cross products and the four dot products.
// Six register stages; depends on rti_pkg.
module rti_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  rti_pkg::t_ray_in i_ray,
    input  rti_pkg::t_vec3  i_v0,
    input  rti_pkg::t_vec3  i_e1,
    input  rti_pkg::t_vec3  i_e2,
    output logic            o_vld,
    input  logic            i_rdy,
    output rti_pkg::t_dots  o_dots
);
    import rti_pkg::*;

    localparam int NS = 6;
    localparam int NX [3] = '{1, 2, 0};
    localparam int NY [3] = '{2, 0, 1};
    localparam int LW = TW + SPLIT_W + 1;
    localparam int HW = TW + XW - SPLIT_W;

    logic [NS:1]   r_vld;
    logic [NS+1:1] rdy;
    t_side         r_side [1:NS];

    t_coord org [3];
    t_coord dir [3];
    t_coord v0  [3];
    t_coord e1  [3];
    t_coord e2  [3];

    logic signed [TW-1:0] r1_t [3];
    t_coord               r1_d [3];
    logic signed [PW-1:0] r2_pa [3];
    logic signed [PW-1:0] r2_pb [3];
    logic signed [PW-1:0] r2_qa [3];
    logic signed [PW-1:0] r2_qb [3];
    logic signed [TW-1:0] r2_t [3];
    t_coord               r2_d [3];
    logic signed [XW-1:0] r3_pv [3];
    logic signed [XW-1:0] r3_qv [3];
    logic signed [TW-1:0] r3_t [3];
    t_coord               r3_d [3];
    logic signed [TW-1:0] a4 [4][3];
    logic signed [XW-1:0] b4 [4][3];
    logic signed [LW-1:0] r4_lo [4][3];
    logic signed [HW-1:0] r4_hi [4][3];
    logic signed [DW-1:0] r5_term [4][3];
    logic signed [DW-1:0] r6_sum [4];

    assign org[0] = i_ray.origin_x;
    assign org[1] = i_ray.origin_y;
    assign org[2] = i_ray.origin_z;
    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;
    assign v0[0]  = i_v0.x;
    assign v0[1]  = i_v0.y;
    assign v0[2]  = i_v0.z;
    assign e1[0]  = i_e1.x;
    assign e1[1]  = i_e1.y;
    assign e1[2]  = i_e1.z;
    assign e2[0]  = i_e2.x;
    assign e2[1]  = i_e2.y;
    assign e2[2]  = i_e2.z;

    // Stage k loads when it is empty or its successor moves
    assign rdy[NS+1] = i_rdy;
    for (genvar g = 1; g <= NS; g++) begin : g_rdy
        assign rdy[g] = !r_vld[g] || rdy[g+1];
    end
    assign o_rdy = rdy[1];
    assign o_vld = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_vld;
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Sideband follows the data
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_side[1].action <= i_ray.action;
            r_side[1].limit  <= i_ray.distance_limit;
        end
        for (int k = 2; k <= NS; k++) begin
            if (rdy[k]) r_side[k] <= r_side[k-1];
        end
    end

    // Stage 1: origin relative to base vertex
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int k = 0; k < 3; k++) begin
                r1_t[k] <= TW'(org[k]) - TW'(v0[k]);
                r1_d[k] <= dir[k];
            end
        end
    end

    // Stage 2: cross product terms of d x e2 and t x e1
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int k = 0; k < 3; k++) begin
                r2_pa[k] <= r1_d[NX[k]] * e2[NY[k]];
                r2_pb[k] <= r1_d[NY[k]] * e2[NX[k]];
                r2_qa[k] <= r1_t[NX[k]] * e1[NY[k]];
                r2_qb[k] <= r1_t[NY[k]] * e1[NX[k]];
                r2_t[k]  <= r1_t[k];
                r2_d[k]  <= r1_d[k];
            end
        end
    end

    // Stage 3: cross product components
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int k = 0; k < 3; k++) begin
                r3_pv[k] <= XW'(r2_pa[k]) - XW'(r2_pb[k]);
                r3_qv[k] <= XW'(r2_qa[k]) - XW'(r2_qb[k]);
                r3_t[k]  <= r2_t[k];
                r3_d[k]  <= r2_d[k];
            end
        end
    end

    // Dot product operands
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a4[DOT_DET][k] = TW'(e1[k]);
            b4[DOT_DET][k] = r3_pv[k];
            a4[DOT_U][k]   = r3_t[k];
            b4[DOT_U][k]   = r3_pv[k];
            a4[DOT_V][k]   = TW'(r3_d[k]);
            b4[DOT_V][k]   = r3_qv[k];
            a4[DOT_W][k]   = TW'(e2[k]);
            b4[DOT_W][k]   = r3_qv[k];
        end
    end

    // Stage 4: partial products, cross component split into two slices
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_lo[j][k] <= a4[j][k] * $signed({1'b0, b4[j][k][SPLIT_W-1:0]});
                    r4_hi[j][k] <= a4[j][k] * $signed(b4[j][k][XW-1:SPLIT_W]);
                end
            end
        end
    end

    // Stage 5: recombine slices
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_term[j][k] <= (DW'(r4_hi[j][k]) <<< SPLIT_W) + DW'(r4_lo[j][k]);
                end
            end
        end
    end

    // Stage 6: sum of three terms
    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            for (int j = 0; j < 4; j++) begin
                r6_sum[j] <= r5_term[j][0] + r5_term[j][1] + r5_term[j][2];
            end
        end
    end

    assign o_dots.side = r_side[NS];
    assign o_dots.det  = r6_sum[DOT_DET];
    assign o_dots.u    = r6_sum[DOT_U];
    assign o_dots.v    = r6_sum[DOT_V];
    assign o_dots.w    = r6_sum[DOT_W];

endmodule

// File: src/rti_classify.sv
// Sign normalization, inside/range tests and divider lane setup.
// Two register stages; depends on rti_pkg.
module rti_classify #(
    parameter int FRAC_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  rti_pkg::t_dots i_dots,
    output logic           o_vld,
    input  logic           i_rdy,
    output rti_pkg::t_divs o_divs
);
    import rti_pkg::*;

    logic                 r_vld7;
    logic                 r_vld8;
    logic                 rdy7;
    logic                 rdy8;
    t_side                r7_side;
    logic                 r7_nz;
    logic signed [DW-1:0] r7_det;
    logic signed [DW-1:0] r7_u;
    logic signed [DW-1:0] r7_v;
    logic signed [DW-1:0] r7_w;
    logic                 neg;
    logic [DW:0]          uv_sum;
    logic [DW-1:0]        rem_d;
    logic                 n_ok;
    t_divs                r_divs;

    assign rdy8  = !r_vld8 || i_rdy;
    assign rdy7  = !r_vld7 || rdy8;
    assign o_rdy = rdy7;
    assign o_vld = r_vld8;
    assign o_divs = r_divs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld7 <= 1'b0;
            r_vld8 <= 1'b0;
        end else begin
            if (rdy7) r_vld7 <= i_vld;
            if (rdy8) r_vld8 <= r_vld7;
        end
    end

    // Stage 7: make the determinant positive
    assign neg = i_dots.det[DW-1];

    always_ff @(posedge i_clk) begin
        if (rdy7) begin
            r7_side <= i_dots.side;
            r7_nz   <= (i_dots.det != '0);
            r7_det  <= neg ? -i_dots.det : i_dots.det;
            r7_u    <= neg ? -i_dots.u   : i_dots.u;
            r7_v    <= neg ? -i_dots.v   : i_dots.v;
            r7_w    <= neg ? -i_dots.w   : i_dots.w;
        end
    end

    // Stage 8: barycentric and distance tests
    always_comb begin
        uv_sum = {1'b0, r7_u} + {1'b0, r7_v};
        rem_d  = $unsigned(r7_w) >> (QW - FRAC_BITS);
        n_ok   = r7_nz
              && !r7_u[DW-1] && ($unsigned(r7_u) <= $unsigned(r7_det))
              && !r7_v[DW-1] && (uv_sum <= {1'b0, r7_det})
              && !r7_w[DW-1] && (r7_w != '0)
              && (rem_d < $unsigned(r7_det));
    end

    always_ff @(posedge i_clk) begin
        if (rdy8) begin
            r_divs.side        <= r7_side;
            r_divs.ok          <= n_ok;
            r_divs.det         <= r7_det;
            r_divs.rem[LANE_D] <= rem_d;
            r_divs.x[LANE_D]   <= r7_w[QW-1:0] << FRAC_BITS;
            r_divs.rem[LANE_B] <= $unsigned(r7_u) >> 1;
            r_divs.x[LANE_B]   <= {r7_u[0], {(QW-1){1'b0}}};
            r_divs.rem[LANE_G] <= $unsigned(r7_v) >> 1;
            r_divs.x[LANE_G]   <= {r7_v[0], {(QW-1){1'b0}}};
        end
    end

endmodule

// File: src/rti_div_step.sv
// One restoring-division step for the three divider lanes, registered.
// Depends on rti_pkg.
module rti_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  rti_pkg::t_divs i_d,
    output logic           o_vld,
    input  logic           i_rdy,
    output rti_pkg::t_divs o_d
);
    import rti_pkg::*;

    logic          r_vld;
    t_divs         r_d;
    t_divs         n_d;
    logic [DW:0]   part [NLANE];
    logic [DW:0]   diff [NLANE];
    logic          ge   [NLANE];

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_d   = r_d;

    // Shift in next dividend bit, subtract when it fits
    always_comb begin
        n_d = i_d;
        for (int l = 0; l < NLANE; l++) begin
            part[l] = {i_d.rem[l], i_d.x[l][QW-1]};
            diff[l] = part[l] - {1'b0, i_d.det};
            ge[l]   = (part[l] >= {1'b0, i_d.det});
            n_d.rem[l] = ge[l] ? diff[l][DW-1:0] : part[l][DW-1:0];
            n_d.x[l]   = {i_d.x[l][QW-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) r_d <= n_d;
    end

endmodule

// File: src/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection block: config registers, pipeline
// chain and output register. Depends on rti_pkg and the rti_ modules it uses.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  ray     | in        | i_in_valid / o_in_ready    | i_in  (t_ray_in)
//  result  | out       | o_out_valid / i_out_ready  | o_out (t_hit_out)
//
// One ray per clock while results are taken; pipe: vector, test, divide, output.
// The 24-stage divider, one quotient bit per stage, sets the depth.
// Reset is synchronous: it clears all valid bits and the config registers.
// Every stage holds while its successor is full and stalled; empty stages
// keep filling, so input is taken during an output stall until the pipe fills.
module ray_triangle_intersect #(
    parameter int FRAC_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [rti_pkg::CFG_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rti_pkg::t_ray_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rti_pkg::t_hit_out o_out
);
    import rti_pkg::*;

    t_vec3             r_v0;
    t_vec3             r_e1;
    t_vec3             r_e2;
    logic [3*NRM_W-1:0] r_nrm;

    logic   front_vld;
    logic   front_rdy;
    t_dots  front_dots;
    logic   div_vld [QW+1];
    logic   div_rdy [QW+1];
    t_divs  div_d   [QW+1];

    logic     r_out_vld;
    t_hit_out r_out;
    t_hit_out n_out;
    logic     out_rdy;
    logic     hit;
    t_divs    fin;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= '0;
            r_e1  <= '0;
            r_e2  <= '0;
            r_nrm <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VERTEX: r_v0  <= t_vec3'(i_cfg_data);
                CFG_EDGE1:  r_e1  <= t_vec3'(i_cfg_data);
                CFG_EDGE2:  r_e2  <= t_vec3'(i_cfg_data);
                CFG_NORMAL: r_nrm <= i_cfg_data[3*NRM_W-1:0];
                default:    r_nrm <= r_nrm;
            endcase
        end
    end

    rti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_ray   (i_in),
        .i_v0    (r_v0),
        .i_e1    (r_e1),
        .i_e2    (r_e2),
        .o_vld   (front_vld),
        .i_rdy   (front_rdy),
        .o_dots  (front_dots)
    );

    rti_classify #(.FRAC_BITS(FRAC_BITS)) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .o_rdy   (front_rdy),
        .i_dots  (front_dots),
        .o_vld   (div_vld[0]),
        .i_rdy   (div_rdy[0]),
        .o_divs  (div_d[0])
    );

    // Divider chain, one quotient bit per stage
    for (genvar g = 0; g < QW; g++) begin : g_div
        rti_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (div_vld[g]),
            .o_rdy   (div_rdy[g]),
            .i_d     (div_d[g]),
            .o_vld   (div_vld[g+1]),
            .i_rdy   (div_rdy[g+1]),
            .o_d     (div_d[g+1])
        );
    end

    // Final distance test and result formatting
    assign fin     = div_d[QW];
    assign out_rdy = !r_out_vld || i_out_ready;
    assign div_rdy[QW] = out_rdy;
    assign hit     = fin.ok && (fin.x[LANE_D] < fin.side.limit);

    always_comb begin
        n_out = '0;
        if (hit) begin
            n_out.hit = 1'b1;
            if (!fin.side.action) begin
                n_out.hit_distance = fin.x[LANE_D];
                n_out.beta         = fin.x[LANE_B][QW-1 -: BARY_W];
                n_out.gamma        = fin.x[LANE_G][QW-1 -: BARY_W];
                n_out.normal_x     = r_nrm[NRM_W-1:0];
                n_out.normal_y     = r_nrm[2*NRM_W-1:NRM_W];
                n_out.normal_z     = r_nrm[3*NRM_W-1:2*NRM_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= div_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: src/rti_checker.sv
// Port-level checks for ray_triangle_intersect and the bind that attaches them.
// Depends on rti_pkg.
module rti_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input rti_pkg::t_hit_out o_out
);
    import rti_pkg::*;

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // A miss carries no record
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.hit |->
            o_out.hit_distance == '0 && o_out.beta == '0 && o_out.gamma == '0
            && o_out.normal_x == '0 && o_out.normal_y == '0 && o_out.normal_z == '0)
        else $error("miss with nonzero record");

    // Barycentrics of a hit stay inside the triangle
    a_bary_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out.beta} + {1'b0, o_out.gamma})
            <= (BARY_W + 1)'(65536))
        else $error("beta plus gamma above one");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);
